/* hdl/lane_hash_128_macros.svh */
// ============================================================================
// lane_hash_128_macros.svh
// Assertion macros for the lane hash block; empty when synthesizing.
// ============================================================================
`ifndef LANE_HASH_128_MACROS_SVH
`define LANE_HASH_128_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lane_hash_128: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lane_hash_128: assertion failed");
`else
`define LH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/lh128_pkg.sv */
// ============================================================================
// lh128_pkg
// Types, constants and microcode fields shared by the lane hash modules.
// ============================================================================
package lh128_pkg;

    // Hash constants
    localparam logic [63:0] PRIME_1  = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME_2  = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME_3  = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME_4  = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] SEED_LO  = 64'h0123456789ABCDEF;
    localparam logic [63:0] SEED_HI  = 64'hFEDCBA9876543210;
    localparam logic [63:0] LO_INIT  = SEED_LO + PRIME_1 + PRIME_2;
    localparam logic [63:0] HI_INIT  = SEED_HI + PRIME_2;
    localparam logic [8:0]  BYTE_TWEAK = 9'h0A5;

    localparam logic [63:0] SECRET_0 = 64'hBE4BA423396CFEB8;
    localparam logic [63:0] SECRET_1 = 64'hC13F483119E6F21D;
    localparam logic [63:0] SECRET_2 = 64'h2ED193E86E126996;

    // Payload types
    typedef struct packed {
        logic [63:0] lane_data;
        logic [3:0]  byte_count;
        logic        last_item;
    } t_lane_in;

    typedef struct packed {
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } t_hash_out;

    // Microcode fields
    typedef enum logic [2:0] {
        OPA_M, OPA_LO, OPA_HI, OPA_LO_XB, OPA_HI_XB
    } t_opa;

    typedef enum logic [1:0] {
        OPB_P1, OPB_P2, OPB_P3, OPB_P4
    } t_opb;

    typedef enum logic [1:0] {
        MP_NONE, MP_LL, MP_HL, MP_LH
    } t_mpart;

    typedef enum logic [2:0] {
        WB_NONE, WB_LO_ADDROT, WB_LO, WB_HI_XOR_M, WB_HI_ROT, WB_HI, WB_HI_BYTE
    } t_wb;

    typedef enum logic [1:0] {
        J_NEXT, J_ZERO, J_GOTO, J_END
    } t_jmp;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    // Program entry points
    localparam t_upc UPC_WORD  = 5'd0;
    localparam t_upc UPC_END   = 5'd17;
    localparam t_upc UPC_BYTES = 5'd18;

    typedef struct packed {
        t_opa   opa;
        t_opb   opb;
        t_mpart mpart;
        t_wb    wb;
        t_jmp   jmp;
        t_upc   target;
    } t_uword;

    localparam t_uword UW_NOP = '{opa: OPA_M, opb: OPB_P1, mpart: MP_NONE,
                                  wb: WB_NONE, jmp: J_NEXT, target: '0};

    // Sequencer status toward the datapath
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    // Secret word for a phase; phase three acts as phase zero
    function automatic logic [63:0] lh_secret(input logic [1:0] ph);
        case (ph)
            2'd1:    lh_secret = SECRET_1;
            2'd2:    lh_secret = SECRET_2;
            default: lh_secret = SECRET_0;
        endcase
    endfunction

    function automatic logic [1:0] lh_next_phase(input logic [1:0] ph);
        case (ph)
            2'd1:    lh_next_phase = 2'd2;
            2'd2:    lh_next_phase = 2'd0;
            default: lh_next_phase = 2'd1;
        endcase
    endfunction

    function automatic logic [63:0] lh_prime(input t_opb sel);
        case (sel)
            OPB_P2:  lh_prime = PRIME_2;
            OPB_P3:  lh_prime = PRIME_3;
            OPB_P4:  lh_prime = PRIME_4;
            default: lh_prime = PRIME_1;
        endcase
    endfunction

endpackage

/* hdl/lh128_urom.sv */
// ============================================================================
// lh128_urom
// Microcode table: one control word per program step.
// ============================================================================
module lh128_urom (
    input  lh128_pkg::t_upc   i_upc,
    output lh128_pkg::t_uword o_uword
);
    import lh128_pkg::*;

    function automatic t_uword uw(input t_opa a, input t_opb b, input t_mpart p,
                                  input t_wb w, input t_jmp j, input t_upc t);
        t_uword r;
        r.opa    = a;
        r.opb    = b;
        r.mpart  = p;
        r.wb     = w;
        r.jmp    = j;
        r.target = t;
        return r;
    endfunction

    // Full word: low then high chain. Partial word: byte loop.
    always_comb begin
        case (i_upc)
            // low = rotl(low + m*P1, 31) * P2
            5'd0:    o_uword = uw(OPA_M,  OPB_P1, MP_LL, WB_NONE, J_NEXT, '0);
            5'd1:    o_uword = uw(OPA_M,  OPB_P1, MP_HL, WB_NONE, J_NEXT, '0);
            5'd2:    o_uword = uw(OPA_M,  OPB_P1, MP_LH, WB_NONE, J_NEXT, '0);
            5'd3:    o_uword = uw(OPA_M,  OPB_P1, MP_NONE, WB_LO_ADDROT, J_NEXT, '0);
            5'd4:    o_uword = uw(OPA_LO, OPB_P2, MP_LL, WB_NONE, J_NEXT, '0);
            5'd5:    o_uword = uw(OPA_LO, OPB_P2, MP_HL, WB_NONE, J_NEXT, '0);
            5'd6:    o_uword = uw(OPA_LO, OPB_P2, MP_LH, WB_NONE, J_NEXT, '0);
            5'd7:    o_uword = uw(OPA_LO, OPB_P2, MP_NONE, WB_LO, J_NEXT, '0);
            // high = rotl((high ^ m) * P3, 27) * P4
            5'd8:    o_uword = uw(OPA_HI, OPB_P3, MP_NONE, WB_HI_XOR_M, J_NEXT, '0);
            5'd9:    o_uword = uw(OPA_HI, OPB_P3, MP_LL, WB_NONE, J_NEXT, '0);
            5'd10:   o_uword = uw(OPA_HI, OPB_P3, MP_HL, WB_NONE, J_NEXT, '0);
            5'd11:   o_uword = uw(OPA_HI, OPB_P3, MP_LH, WB_NONE, J_NEXT, '0);
            5'd12:   o_uword = uw(OPA_HI, OPB_P3, MP_NONE, WB_HI_ROT, J_NEXT, '0);
            5'd13:   o_uword = uw(OPA_HI, OPB_P4, MP_LL, WB_NONE, J_NEXT, '0);
            5'd14:   o_uword = uw(OPA_HI, OPB_P4, MP_HL, WB_NONE, J_NEXT, '0);
            5'd15:   o_uword = uw(OPA_HI, OPB_P4, MP_LH, WB_NONE, J_NEXT, '0);
            5'd16:   o_uword = uw(OPA_HI, OPB_P4, MP_NONE, WB_HI, J_NEXT, '0);
            // finish the transaction
            5'd17:   o_uword = uw(OPA_M,  OPB_P1, MP_NONE, WB_NONE, J_END, '0);
            // byte loop: leave when no bytes remain
            5'd18:   o_uword = uw(OPA_LO_XB, OPB_P1, MP_NONE, WB_NONE, J_ZERO, UPC_END);
            5'd19:   o_uword = uw(OPA_LO_XB, OPB_P1, MP_LL, WB_NONE, J_NEXT, '0);
            5'd20:   o_uword = uw(OPA_LO_XB, OPB_P1, MP_HL, WB_NONE, J_NEXT, '0);
            5'd21:   o_uword = uw(OPA_LO_XB, OPB_P1, MP_LH, WB_NONE, J_NEXT, '0);
            5'd22:   o_uword = uw(OPA_LO_XB, OPB_P1, MP_NONE, WB_LO, J_NEXT, '0);
            5'd23:   o_uword = uw(OPA_HI_XB, OPB_P2, MP_LL, WB_NONE, J_NEXT, '0);
            5'd24:   o_uword = uw(OPA_HI_XB, OPB_P2, MP_HL, WB_NONE, J_NEXT, '0);
            5'd25:   o_uword = uw(OPA_HI_XB, OPB_P2, MP_LH, WB_NONE, J_NEXT, '0);
            5'd26:   o_uword = uw(OPA_HI_XB, OPB_P2, MP_NONE, WB_HI_BYTE, J_GOTO,
                                  UPC_BYTES);
            default: o_uword = UW_NOP;
        endcase
    end

endmodule

/* hdl/lh128_mul.sv */
// ============================================================================
// lh128_mul
// 64x64 multiply modulo 2^64 built from three 32x32 partial products.
// ============================================================================
module lh128_mul (
    input  logic              i_clk,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  lh128_pkg::t_mpart i_part,
    output logic [63:0]       o_prod
);
    import lh128_pkg::*;

    logic [31:0] a32;
    logic [31:0] b32;
    logic [63:0] pp;
    logic [63:0] r_prod;

    // Pick the halves for this partial product
    assign a32 = (i_part == MP_HL) ? i_a[63:32] : i_a[31:0];
    assign b32 = (i_part == MP_LH) ? i_b[63:32] : i_b[31:0];
    assign pp  = 64'(a32) * 64'(b32);

    // Start with low x low, then add cross terms into the upper half
    always_ff @(posedge i_clk) begin
        case (i_part)
            MP_LL:        r_prod <= pp;
            MP_HL, MP_LH: r_prod <= {r_prod[63:32] + pp[31:0], r_prod[31:0]};
            default:      r_prod <= r_prod;
        endcase
    end

    assign o_prod = r_prod;

endmodule

/* hdl/lh128_seq.sv */
// ============================================================================
// lh128_seq
// Microprogram sequencer: step counter, conditional jumps, end handshake.
// ============================================================================
module lh128_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  lh128_pkg::t_upc       i_entry,
    input  logic                  i_zero,
    input  logic                  i_hold,
    output lh128_pkg::t_uword     o_uword,
    output lh128_pkg::t_seq_stat  o_stat
);
    import lh128_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state r_state, n_state;
    t_upc   r_upc, n_upc;
    t_uword rom_word;

    lh128_urom u_urom (
        .i_upc   (r_upc),
        .o_uword (rom_word)
    );

    // Advance the step counter
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_upc   = i_entry;
                end
            end
            S_RUN: begin
                case (rom_word.jmp)
                    J_ZERO:  n_upc = i_zero ? rom_word.target : r_upc + 1'b1;
                    J_GOTO:  n_upc = rom_word.target;
                    J_END: begin
                        if (!i_hold) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_upc = r_upc + 1'b1;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_upc   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    assign o_uword     = (r_state == S_RUN) ? rom_word : UW_NOP;
    assign o_stat.busy = (r_state == S_RUN);
    assign o_stat.done = (r_state == S_RUN) && (rom_word.jmp == J_END) && !i_hold;

endmodule

/* hdl/lane_hash_128.sv */
// ============================================================================
// lane_hash_128
// Streaming 128-bit message hash over 64-bit little-endian lanes.
// ============================================================================
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+----------------------------
//  in      | in  | i_in_valid / o_in_ready    | i_in_data  (t_lane_in)
//  out     | out | o_out_valid / i_out_ready  | o_out_data (t_hash_out)
//
//  One transaction at a time; o_in_ready is high whenever the sequencer idles.
//  The shared 32x32 multiplier takes three passes per 64-bit multiply.
//  Reset is synchronous; it returns the accumulators to values derived from the seeds.
//  A result waits in the output register; a new transaction is taken while it
//  waits, and the sequencer stalls at its final step only if it must emit.
//
module lane_hash_128 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lh128_pkg::t_lane_in   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lh128_pkg::t_hash_out  o_out_data
);
    import lh128_pkg::*;

    `include "lane_hash_128_macros.svh"

    t_uword    uword;
    t_seq_stat stat;

    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic [1:0]  r_phase;
    logic [63:0] r_data;
    logic [63:0] r_m;
    logic [2:0]  r_count;
    logic        r_emit;
    logic        r_full;
    logic        r_out_valid;
    t_hash_out   r_out;

    logic        in_fire;
    logic        full_in;
    logic        hold;
    logic [7:0]  cur_byte;
    logic [8:0]  tweak_byte;
    logic [63:0] op_a;
    logic [63:0] prod;
    logic [63:0] lo_sum;

    assign in_fire    = i_in_valid && o_in_ready;
    assign full_in    = i_in_data.byte_count[3];
    assign hold       = r_emit && r_out_valid && !i_out_ready;
    assign cur_byte   = r_data[7:0];
    assign tweak_byte = {1'b0, cur_byte} + BYTE_TWEAK;
    assign lo_sum     = r_lo + prod;

    lh128_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_entry (full_in ? UPC_WORD : UPC_BYTES),
        .i_zero  (r_count == 3'd0),
        .i_hold  (hold),
        .o_uword (uword),
        .o_stat  (stat)
    );

    // Select the multiplier operand
    always_comb begin
        case (uword.opa)
            OPA_LO:    op_a = r_lo;
            OPA_HI:    op_a = r_hi;
            OPA_LO_XB: op_a = r_lo ^ {56'd0, cur_byte};
            OPA_HI_XB: op_a = r_hi ^ {55'd0, tweak_byte};
            default:   op_a = r_m;
        endcase
    end

    lh128_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (op_a),
        .i_b    (lh_prime(uword.opb)),
        .i_part (uword.mpart),
        .o_prod (prod)
    );

    // Capture the transaction; shift out the used byte after each byte step
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data  <= i_in_data.lane_data;
            r_m     <= i_in_data.lane_data ^ lh_secret(r_phase);
            r_count <= full_in ? 3'd0 : i_in_data.byte_count[2:0];
            r_emit  <= i_in_data.last_item || !full_in;
            r_full  <= full_in;
        end else if (uword.wb == WB_HI_BYTE) begin
            r_data  <= {8'd0, r_data[63:8]};
            r_count <= r_count - 3'd1;
        end
    end

    // Accumulator write-back and end of transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= LO_INIT;
            r_hi    <= HI_INIT;
            r_phase <= 2'd0;
        end else if (stat.done) begin
            if (r_emit) begin
                r_lo    <= LO_INIT;
                r_hi    <= HI_INIT;
                r_phase <= 2'd0;
            end else if (r_full) begin
                r_phase <= lh_next_phase(r_phase);
            end
        end else begin
            case (uword.wb)
                WB_LO_ADDROT: r_lo <= {lo_sum[32:0], lo_sum[63:33]};
                WB_LO:        r_lo <= prod;
                WB_HI_XOR_M:  r_hi <= r_hi ^ r_m;
                WB_HI_ROT:    r_hi <= {prod[36:0], prod[63:37]};
                WB_HI,
                WB_HI_BYTE:   r_hi <= prod;
                default:      r_hi <= r_hi;
            endcase
        end
    end

    // Output register: load the hash, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && r_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && r_emit) begin
            r_out.hash_low  <= r_lo;
            r_out.hash_high <= r_hi;
        end
    end

    assign o_in_ready  = !stat.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `LH_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, stat.busy)
    `LH_ASSERT_NEXT(a_emit_loads_hash, i_clk, i_rst_n, stat.done && r_emit,
                    o_out_valid && (o_out_data.hash_low == $past(r_lo))
                    && (o_out_data.hash_high == $past(r_hi)))
    `LH_ASSERT_NEXT(a_emit_resets_phase, i_clk, i_rst_n, stat.done && r_emit, r_phase == 2'd0 && r_lo == LO_INIT)
    `LH_ASSERT_IMPL(a_phase_range, i_clk, i_rst_n, 1'b1, r_phase != 2'd3)
    `LH_ASSERT_IMPL(a_hold_needs_result, i_clk, i_rst_n, hold, o_out_valid)

endmodule
